/* hw/rtl/pcr_pkg.sv */
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared types and constants for the prime range counter.
// ----------------------------------------------------------------------------
package pcr_pkg;

    localparam int unsigned COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic load;
        logic cand_next;
        logic div_init;
        logic div_start;
        logic div_step;
        logic div_adv;
        logic count_inc;
    } pcr_cmd_t;

    typedef struct packed {
        logic range_empty;
        logic cand_done;
        logic cand_small;
        logic sq_above;
        logic div_last;
        logic rem_zero;
    } pcr_status_t;

endpackage

/* hw/rtl/pcr_datapath.sv */
// ----------------------------------------------------------------------------
// pcr_datapath
// Candidate walk, trial divisor with running square, bit-serial remainder
// unit and saturating prime counter.
// ----------------------------------------------------------------------------
module pcr_datapath #(
    parameter int unsigned VALUE_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pcr_pkg::pcr_cmd_t            cmd,
    input  logic [VALUE_WIDTH-1:0]       range_low,
    input  logic [VALUE_WIDTH-1:0]       range_high,
    output pcr_pkg::pcr_status_t         status,
    output logic [pcr_pkg::COUNT_W-1:0]  prime_count
);

    localparam int unsigned W     = VALUE_WIDTH;
    localparam int unsigned SQ_W  = W + 2;
    localparam int unsigned CNT_W = $clog2(W);

    logic [W-1:0]                lo_reg;
    logic [W-1:0]                hi_reg;
    logic [W:0]                  cand_reg;
    logic [W-1:0]                div_reg;
    logic [SQ_W-1:0]             sq_reg;
    logic [W-1:0]                rem_reg;
    logic [W-1:0]                rem_next;
    logic [W-1:0]                dvd_reg;
    logic [CNT_W-1:0]            bit_reg;
    logic [pcr_pkg::COUNT_W-1:0] count_reg;
    logic [W:0]                  trial;
    logic [W:0]                  trial_diff;

    // one restoring step of the remainder
    assign trial      = {rem_reg, dvd_reg[W-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign rem_next   = (trial >= {1'b0, div_reg}) ? trial_diff[W-1:0] : trial[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cand_reg  <= '0;
            div_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                count_reg <= '0;
                cand_reg  <= {1'b0, range_low};
            end
            else
            begin
                if (cmd.cand_next)
                begin
                    cand_reg <= cand_reg + 1'b1;
                end
                if (cmd.count_inc && (count_reg != pcr_pkg::COUNT_MAX))
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.div_init)
            begin
                div_reg <= W'(2);
            end
            else if (cmd.div_adv)
            begin
                div_reg <= div_reg + 1'b1;
            end
            if (cmd.div_start)
            begin
                rem_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                rem_reg <= rem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_reg <= range_low;
            hi_reg <= range_high;
        end
        if (cmd.div_init)
        begin
            sq_reg <= SQ_W'(4);
        end
        else if (cmd.div_adv)
        begin
            sq_reg <= sq_reg + {1'b0, div_reg, 1'b1};
        end
        if (cmd.div_start)
        begin
            dvd_reg <= cand_reg[W-1:0];
            bit_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            bit_reg <= bit_reg + 1'b1;
        end
    end

    assign status.range_empty = lo_reg > hi_reg;
    assign status.cand_done   = cand_reg > {1'b0, hi_reg};
    assign status.cand_small  = cand_reg < (W+1)'(2);
    assign status.sq_above    = sq_reg > {1'b0, cand_reg};
    assign status.div_last    = bit_reg == CNT_W'(W - 1);
    assign status.rem_zero    = rem_reg == '0;

    assign prime_count = count_reg;

endmodule

/* hw/rtl/pcr_ctrl.sv */
// ----------------------------------------------------------------------------
// pcr_ctrl
// Sequencer: walks candidates, trial divisors and remainder steps.
// ----------------------------------------------------------------------------
module pcr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  pcr_pkg::pcr_status_t status,
    output pcr_pkg::pcr_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CAND,
        ST_CHECK,
        ST_DIV,
        ST_JUDGE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (status.range_empty)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CAND;
                end
            end
            ST_CAND:
            begin
                priority if (status.cand_done)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.cand_small)
                begin
                    cmd.cand_next = 1'b1;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.sq_above)
                begin
                    cmd.count_inc = 1'b1;
                    cmd.cand_next = 1'b1;
                    state_next    = ST_CAND;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE:
            begin
                if (status.rem_zero)
                begin
                    cmd.cand_next = 1'b1;
                    state_next    = ST_CAND;
                end
                else
                begin
                    cmd.div_adv = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = state_next != ST_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    a_busy_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != ST_IDLE))
        else $error("busy flag out of step with state");

    a_done_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("done without a finished request");

    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> (busy_reg && !done_reg))
        else $error("accepted word did not start work");

    a_div_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && status.div_last) |=> (state_reg == ST_JUDGE))
        else $error("remainder unit overran");

endmodule

/* hw/rtl/prime_count_in_range.sv */
// ----------------------------------------------------------------------------
// prime_count_in_range
// Counts the primes in an inclusive range by trial division.
// ----------------------------------------------------------------------------
// A word (range_low, range_high) is taken on a clock edge with start high and
// busy low. busy rises on the next cycle and stays high until the result.
// The result word prime_count is valid for the single cycle in which done is
// high; busy is already low then, so the next word may start in that cycle.
// The receiver cannot stall; prime_count holds until the next word starts.
// The time a word takes is data dependent: it grows with each candidate, and
// for every candidate of 2 or more with each divisor check and each trial
// divisor, where divisors run from 2 while d*d <= candidate and stop at the
// first exact one. The bit-serial remainder unit works one quotient bit per
// cycle. An empty range (low above high) returns 0.
// Reset clears the sequencer and count; the block comes up idle.
// ----------------------------------------------------------------------------
module prime_count_in_range #(
    parameter int unsigned VALUE_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [VALUE_WIDTH-1:0]       range_low,
    input  logic [VALUE_WIDTH-1:0]       range_high,
    output logic                         done,
    output logic [pcr_pkg::COUNT_W-1:0]  prime_count
);

    pcr_pkg::pcr_cmd_t    cmd;
    pcr_pkg::pcr_status_t status;

    pcr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    pcr_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .range_low   (range_low),
        .range_high  (range_high),
        .status      (status),
        .prime_count (prime_count)
    );

endmodule

/* sim/prime_count_checker.sv */
// ----------------------------------------------------------------------------
// prime_count_checker
// Watches the request and result ports of the prime range counter, predicts
// the count for every accepted word by trial division and compares it with
// the result word that comes back in order.
// ----------------------------------------------------------------------------
module prime_count_checker #(
    parameter int unsigned VALUE_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [VALUE_WIDTH-1:0]       range_low,
    input  logic [VALUE_WIDTH-1:0]       range_high,
    input  logic                         done,
    input  logic [pcr_pkg::COUNT_W-1:0]  prime_count,
    output int                           mismatches,
    output int                           outstanding
);

    logic [pcr_pkg::COUNT_W-1:0] expected_counts[$];
    logic [pcr_pkg::COUNT_W-1:0] wanted_count;
    int                          error_tally = 0;

    function automatic bit is_prime(input int unsigned n);
        int unsigned d;
        if (n < 2)
            return 1'b0;
        for (d = 2; d * d <= n; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // candidate runs as a 32-bit count so a range ending at the top value ends
    function automatic logic [pcr_pkg::COUNT_W-1:0] primes_in_range(
        input int unsigned lo,
        input int unsigned hi
    );
        int unsigned n;
        int unsigned tally;
        tally = 0;
        if (lo <= hi)
        begin
            for (n = lo; n <= hi; n++)
            begin
                if (is_prime(n) && tally < pcr_pkg::COUNT_MAX)
                    tally++;
            end
        end
        return tally[pcr_pkg::COUNT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        error_tally++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_counts.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_counts.size() == 0)
                    report_mismatch($sformatf("result word %0d with no request pending",
                                              prime_count));
                else
                begin
                    wanted_count = expected_counts.pop_front();
                    if (prime_count !== wanted_count)
                        report_mismatch($sformatf("prime_count %0d, expected %0d",
                                                  prime_count, wanted_count));
                end
            end
            if (start && !busy)
                expected_counts.push_back(primes_in_range(32'(range_low),
                                                          32'(range_high)));
            mismatches  <= error_tally;
            outstanding <= expected_counts.size();
        end
    end

endmodule

/* sim/prime_count_in_range_tb.sv */
// ----------------------------------------------------------------------------
// prime_count_in_range_tb
// Drives range requests into the prime range counter: a directed set of
// edge ranges (empty, single values, the top of the range, small primes),
// then random ranges weighted toward short spans, with random gaps on the
// request side. A checker beside the block scores every result word.
// ----------------------------------------------------------------------------
module prime_count_in_range_tb;

    localparam int unsigned VALUE_WIDTH    = 16;
    localparam int unsigned VALUE_MAX      = (1 << VALUE_WIDTH) - 1;
    localparam int unsigned RANDOM_WORDS   = 90;
    localparam int unsigned QUIET_FIRST    = 20;
    localparam int unsigned QUIET_LAST     = 49;
    localparam int unsigned WATCHDOG_LIMIT = 200000;

    logic                         clk        = 1'b0;
    logic                         rst_n      = 1'b0;
    logic                         start      = 1'b0;
    logic [VALUE_WIDTH-1:0]       range_low  = '0;
    logic [VALUE_WIDTH-1:0]       range_high = '0;
    logic                         busy;
    logic                         done;
    logic [pcr_pkg::COUNT_W-1:0]  prime_count;
    int                           mismatches;
    int                           outstanding;
    int                           stalled_cycles = 0;

    always #5 clk = ~clk;

    prime_count_in_range #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .range_low   (range_low),
        .range_high  (range_high),
        .done        (done),
        .prime_count (prime_count)
    );

    prime_count_checker #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .range_low   (range_low),
        .range_high  (range_high),
        .done        (done),
        .prime_count (prime_count),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // start stays high into the next word unless a gap is taken
    task automatic send_range(input int unsigned lo, input int unsigned hi,
                              input bit may_idle);
        if (may_idle && $urandom_range(99) < 25)
        begin
            start <= 1'b0;
            repeat ($urandom_range(30, 1)) @(posedge clk);
        end
        start      <= 1'b1;
        range_low  <= lo[VALUE_WIDTH-1:0];
        range_high <= hi[VALUE_WIDTH-1:0];
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_all_counts;
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stalled_cycles <= 0;
        else if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial
    begin
        int unsigned lo;
        int unsigned hi;
        int unsigned pick;
        bit          may_idle;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_range(0, 0, 1'b1);
        send_range(0, 1, 1'b1);
        send_range(1, 1, 1'b1);
        send_range(2, 2, 1'b1);
        send_range(3, 4, 1'b1);
        send_range(4, 4, 1'b0);
        send_range(0, 300, 1'b1);
        send_range(1, 0, 1'b0);
        send_range(VALUE_MAX, 0, 1'b1);
        send_range(100, 99, 1'b0);
        send_range(VALUE_MAX, VALUE_MAX, 1'b1);
        send_range(VALUE_MAX - 1, VALUE_MAX, 1'b0);
        send_range(65521, VALUE_MAX, 1'b1);
        send_range(32'hAAAA, 32'hAAB4, 1'b1);
        send_range(32'h5555, 32'h5560, 1'b0);
        send_range(32749, 32771, 1'b1);
        send_range(32'h8000, 32'h8008, 1'b0);
        send_range(32'h7FF8, 32'h7FFF, 1'b1);
        wait_all_counts();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                hi = $urandom_range(VALUE_MAX - 1);
                lo = $urandom_range(VALUE_MAX, hi + 1);
            end
            else if (pick < 25)
            begin
                lo = $urandom_range(1023);
                hi = lo + $urandom_range(63);
            end
            else
            begin
                lo = $urandom_range(VALUE_MAX);
                hi = lo + $urandom_range(7);
                if (hi > VALUE_MAX)
                    hi = VALUE_MAX;
            end
            may_idle = !(i >= QUIET_FIRST && i <= QUIET_LAST);
            send_range(lo, hi, may_idle);
            if (may_idle && $urandom_range(19) == 0)
                wait_all_counts();
        end

        wait_all_counts();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
